FILE: rtl/deps_pkg.sv
// package: shared types and constants for the dtmf event packet sequencer
`default_nettype none

package deps_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned StampWidth    = 32;
   localparam int unsigned DivCountWidth = 5;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_VOLUME_LEVEL       = 3'd0,
      CSR_TONE_TIME_MS       = 3'd1,
      CSR_PAUSE_TIME_MS      = 3'd2,
      CSR_PACKET_TIME_MS     = 3'd3,
      CSR_SAMPLES_PER_PACKET = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } seq_state_type;

   typedef enum logic {
      MODE_START  = 1'b0,
      MODE_PACKET = 1'b1
   } req_mode_type;

   localparam logic [5:0]  VolumeReset     = 6'd10;
   localparam logic [15:0] ToneTimeReset   = 16'd100;
   localparam logic [15:0] PauseTimeReset  = 16'd40;
   localparam logic [7:0]  PacketTimeReset = 8'd20;
   localparam logic [15:0] SamplesReset    = 16'd160;

endpackage

`default_nettype wire

FILE: rtl/deps_req_if.sv
// interface: request channel carrying start and packet beats
`default_nettype none

interface deps_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [7:0]  event_code;
   logic [31:0] stamp;

   modport source (output valid, output mode, output event_code, output stamp, input ready);
   modport sink (input valid, input mode, input event_code, input stamp, output ready);
endinterface

`default_nettype wire

FILE: rtl/deps_rsp_if.sv
// interface: response channel carrying telephone event packet fields
`default_nettype none

interface deps_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_event;
   logic        end_bit;
   logic [5:0]  out_volume;
   logic [15:0] event_duration;
   logic [31:0] packet_stamp;
   logic        done_flag;

   modport source (
      output valid, output out_event, output end_bit, output out_volume,
      output event_duration, output packet_stamp, output done_flag, input ready
   );
   modport sink (
      input valid, input out_event, input end_bit, input out_volume,
      input event_duration, input packet_stamp, input done_flag, output ready
   );
endinterface

`default_nettype wire

FILE: rtl/dtmf_event_packet_sequencer_unit.sv
// top level: dtmf telephone event packet sequencer with shared serial divider
//
//  channel   direction  beat contents
//  req_chan  in         mode, event_code, stamp
//  rsp_chan  out        out_event, end_bit, out_volume, event_duration, packet_stamp, done_flag
//  csr_*     in         csr_wr_en, csr_index, csr_wr_data (write only)
//
//  start beat: taken in idle, no response
//  packet beat: accept, 32 restoring divide steps, multiply, finish
//  the one-bit-per-cycle divider by samples per packet sets the packet latency
//  req ready only in idle; a held response stalls the finish step, not the divide
//  reset is synchronous active high and restores config defaults and event state
`default_nettype none

module dtmf_event_packet_sequencer_unit
   import deps_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   deps_req_if.sink                 req_chan,
   deps_rsp_if.source               rsp_chan,
   input  wire                      csr_wr_en,
   input  wire [CsrIndexWidth-1:0]  csr_index,
   input  wire [CsrDataWidth-1:0]   csr_wr_data
);

   localparam logic [DivCountWidth-1:0] DivLast = DivCountWidth'(StampWidth - 1);

   seq_state_type state_ff, state_in;

   logic [5:0]  volume_ff;
   logic [15:0] tone_time_ff;
   logic [15:0] pause_time_ff;
   logic [7:0]  packet_time_ff;
   logic [15:0] samples_ff;

   logic [31:0] start_stamp_ff;
   logic [7:0]  held_event_ff;
   logic        in_pause_ff;
   logic        stopped_ff;
   logic [31:0] tone_length_ff;

   logic [15:0] ns_ff;
   logic [7:0]  pt_ff;
   logic [15:0] limit_ff;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [DivCountWidth-1:0] cnt_ff;
   logic [23:0] prod_ff;
   logic        qbig_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_event_ff;
   logic        rsp_end_ff;
   logic [5:0]  rsp_volume_ff;
   logic [15:0] rsp_duration_ff;
   logic [31:0] rsp_stamp_ff;
   logic        rsp_done_ff;

   logic        req_ready;
   logic        req_beat;
   logic        fin_go;
   logic        out_free;
   logic [15:0] ns_eff;
   logic [31:0] play_span;
   logic [31:0] pause_raw;
   logic [31:0] pause_span;
   logic [16:0] trial;
   logic [16:0] trial_diff;
   logic        trial_ge;
   logic        reached;
   logic        end_now;
   logic        stopped_now;
   logic [31:0] duration_src;

   // span arithmetic at accept
   assign ns_eff     = (samples_ff == 16'd0) ? 16'd1 : samples_ff;
   assign play_span  = req_chan.stamp - start_stamp_ff + {16'd0, ns_eff};
   assign pause_raw  = req_chan.stamp - start_stamp_ff - tone_length_ff + {16'd0, ns_eff};
   assign pause_span = pause_raw[31] ? 32'd0 : pause_raw;

   // restoring divide step
   assign trial      = {rem_ff, quo_ff[31]};
   assign trial_diff = trial - {1'b0, ns_ff};
   assign trial_ge   = trial >= {1'b0, ns_ff};

   always_comb begin
      rem_in = trial_ge ? trial_diff[15:0] : trial[15:0];
      quo_in = {quo_ff[30:0], trial_ge};
   end

   assign reached      = qbig_ff || (prod_ff >= {8'd0, limit_ff});
   assign end_now      = in_pause_ff || reached;
   assign stopped_now  = stopped_ff || (in_pause_ff && reached);
   assign duration_src = tone_length_ff;
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign req_beat     = req_chan.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_chan.mode == MODE_PACKET) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == DivLast) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      fin_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV:  req_ready = 1'b0;
         ST_MUL:  req_ready = 1'b0;
         ST_FIN:  fin_go = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_event      = rsp_event_ff;
   assign rsp_chan.end_bit        = rsp_end_ff;
   assign rsp_chan.out_volume     = rsp_volume_ff;
   assign rsp_chan.event_duration = rsp_duration_ff;
   assign rsp_chan.packet_stamp   = rsp_stamp_ff;
   assign rsp_chan.done_flag      = rsp_done_ff;

   // control, config and event state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         volume_ff      <= VolumeReset;
         tone_time_ff   <= ToneTimeReset;
         pause_time_ff  <= PauseTimeReset;
         packet_time_ff <= PacketTimeReset;
         samples_ff     <= SamplesReset;
         start_stamp_ff <= 32'd0;
         held_event_ff  <= 8'd0;
         in_pause_ff    <= 1'b0;
         stopped_ff     <= 1'b0;
         tone_length_ff <= 32'd0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_VOLUME_LEVEL:       volume_ff      <= csr_wr_data[5:0];
               CSR_TONE_TIME_MS:       tone_time_ff   <= csr_wr_data;
               CSR_PAUSE_TIME_MS:      pause_time_ff  <= csr_wr_data;
               CSR_PACKET_TIME_MS:     packet_time_ff <= csr_wr_data[7:0];
               CSR_SAMPLES_PER_PACKET: samples_ff     <= csr_wr_data;
               default: ;
            endcase
         end
         if (req_beat) begin
            cnt_ff <= '0;
            if (req_chan.mode == MODE_START) begin
               held_event_ff  <= req_chan.event_code;
               start_stamp_ff <= req_chan.stamp;
               in_pause_ff    <= 1'b0;
               stopped_ff     <= 1'b0;
               tone_length_ff <= 32'd0;
            end else if (!in_pause_ff) begin
               tone_length_ff <= play_span;
            end
         end
         if (state_ff == ST_DIV) cnt_ff <= cnt_ff + DivCountWidth'(1);
         if (fin_go) begin
            in_pause_ff  <= end_now;
            stopped_ff   <= stopped_now;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         ns_ff    <= ns_eff;
         pt_ff    <= packet_time_ff;
         limit_ff <= in_pause_ff ? pause_time_ff : tone_time_ff;
         rem_ff   <= 16'd0;
         quo_ff   <= in_pause_ff ? pause_span : play_span;
      end else if (state_ff == ST_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= {8'd0, quo_ff[15:0]} * {16'd0, pt_ff};
         qbig_ff <= (|quo_ff[31:16]) && (pt_ff != 8'd0);
      end
      if (fin_go) begin
         rsp_event_ff    <= held_event_ff;
         rsp_end_ff      <= end_now;
         rsp_volume_ff   <= volume_ff;
         rsp_duration_ff <= (|duration_src[31:16]) ? 16'hFFFF : duration_src[15:0];
         rsp_stamp_ff    <= start_stamp_ff;
         rsp_done_ff     <= stopped_now;
      end
   end

   a_div_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DivLast) |=> (state_ff == ST_MUL))
      else $error("divide did not hand over to multiply");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < ns_ff))
      else $error("partial remainder not below divisor");

   a_stop_in_pause: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> in_pause_ff)
      else $error("finished flag set outside pause phase");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response beat loaded outside finish step");

endmodule

`default_nettype wire
